// ===== rtl/conv3x3_window_mac_engine_assert.svh =====
// ----------------------------------------------------------------------------
// conv3x3 window mac engine assertion macros
// shared property forms for the engine's checker
// ----------------------------------------------------------------------------
`ifndef CONV3X3_WINDOW_MAC_ENGINE_ASSERT_SVH
`define CONV3X3_WINDOW_MAC_ENGINE_ASSERT_SVH

// same-cycle check that also holds while reset is applied
`define CWM_ASSERT_ALWAYS(label, ante, cons) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("cwm check failed");

// next-cycle check, switched off during reset
`define CWM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cwm check failed");

`endif

// ===== rtl/cwm_pkg.sv =====
// ----------------------------------------------------------------------------
// cwm_pkg
// shared widths, codes and types of the 3x3 window mac engine
// ----------------------------------------------------------------------------
package cwm_pkg;

	localparam int LANES_DEFAULT = 16;
	localparam int KSIZE         = 3;
	localparam int TAPS          = KSIZE * KSIZE;

	localparam int PIX_W    = 8;
	localparam int LANE_W   = 4;
	localparam int KROW_W   = 2;
	localparam int ROW_W    = 12;
	localparam int COL_W    = 13;
	localparam int DIM_W    = 13;
	localparam int STRIDE_W = 3;
	localparam int PAD_W    = 2;
	localparam int SUM_W    = 32;
	localparam int OP_W     = 2;

	// adder tree widths: 9 products per lane, 8 lanes per group
	localparam int PROD_W      = 2 * PIX_W;
	localparam int LSUM_W      = PROD_W + 4;
	localparam int GROUP_LANES = 8;
	localparam int GSUM_W      = LSUM_W + 3;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PADDING = 2'd3;

	localparam logic [DIM_W-1:0]    HEIGHT_RST  = 13'd112;
	localparam logic [DIM_W-1:0]    WIDTH_RST   = 13'd112;
	localparam logic [STRIDE_W-1:0] STRIDE_RST  = 3'd1;
	localparam logic [PAD_W-1:0]    PADDING_RST = 2'd1;

	localparam logic FUNC_WEIGHT = 1'b0;
	localparam logic FUNC_PIXEL  = 1'b1;

	localparam logic [OP_W-1:0] OP_NOP    = 2'd0;
	localparam logic [OP_W-1:0] OP_WEIGHT = 2'd1;
	localparam logic [OP_W-1:0] OP_PIXEL  = 2'd2;

	typedef logic signed [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic [DIM_W-1:0]    height;
		logic [DIM_W-1:0]    width;
		logic [STRIDE_W-1:0] stride;
		logic [PAD_W-1:0]    padding;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [LANE_W-1:0]        lane;
		logic [KROW_W-1:0]        krow;
		pix_t [KSIZE-1:0]         vals;
		logic                     emit;
		logic signed [SUM_W-1:0]  prior;
	} cmd_t;

endpackage

// ===== rtl/cwm_fifo.sv =====
// ----------------------------------------------------------------------------
// cwm_fifo
// small register queue with occupancy count
// ----------------------------------------------------------------------------
module cwm_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic                         pop,
	input  logic [W-1:0]                 din,
	output logic [W-1:0]                 dout,
	output logic [$clog2(DEPTH+1)-1:0]   count,
	output logic                         full,
	output logic                         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr;
	logic             rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign wr    = push && !full;
	assign rd    = pop && !empty;
	assign dout  = mem_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr, rd})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				2'b00: count_q <= count_q;
				2'b11: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/cwm_front.sv =====
// ----------------------------------------------------------------------------
// cwm_front
// geometry registers and item classification with border zeroing
// ----------------------------------------------------------------------------
module cwm_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [cwm_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [cwm_pkg::DIM_W-1:0]           wr_data,
	input  logic                                func,
	input  logic [cwm_pkg::LANE_W-1:0]          lane,
	input  logic [cwm_pkg::KROW_W-1:0]          kernel_row,
	input  logic signed [cwm_pkg::PIX_W-1:0]    first_value,
	input  logic signed [cwm_pkg::PIX_W-1:0]    second_value,
	input  logic signed [cwm_pkg::PIX_W-1:0]    third_value,
	input  logic [cwm_pkg::ROW_W-1:0]           out_row,
	input  logic signed [cwm_pkg::COL_W-1:0]    in_col,
	input  logic                                emit,
	input  logic signed [cwm_pkg::SUM_W-1:0]    prior_sum,
	output cwm_pkg::cmd_t                       cmd
);

	localparam int BASE_W = cwm_pkg::ROW_W + cwm_pkg::STRIDE_W;
	localparam int HI_W   = BASE_W + 2;

	cwm_pkg::cfg_t            cfg_q;
	cwm_pkg::pix_t            vin [cwm_pkg::KSIZE];
	logic [BASE_W-1:0]        row_base;
	logic signed [HI_W-1:0]   hi [cwm_pkg::KSIZE];
	logic [cwm_pkg::KSIZE-1:0] row_in;
	logic                     col_in;

	assign vin[0] = first_value;
	assign vin[1] = second_value;
	assign vin[2] = third_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.height  <= cwm_pkg::HEIGHT_RST;
			cfg_q.width   <= cwm_pkg::WIDTH_RST;
			cfg_q.stride  <= cwm_pkg::STRIDE_RST;
			cfg_q.padding <= cwm_pkg::PADDING_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				cwm_pkg::REG_HEIGHT:  cfg_q.height  <= wr_data;
				cwm_pkg::REG_WIDTH:   cfg_q.width   <= wr_data;
				cwm_pkg::REG_STRIDE:  cfg_q.stride  <= wr_data[cwm_pkg::STRIDE_W-1:0];
				cwm_pkg::REG_PADDING: cfg_q.padding <= wr_data[cwm_pkg::PAD_W-1:0];
			endcase
		end
	end

	// first input row of the window, before the padding is taken off
	assign row_base = BASE_W'(out_row) * BASE_W'(cfg_q.stride);

	// negative columns fail on the sign bit
	assign col_in = !in_col[cwm_pkg::COL_W-1]
		&& ({1'b0, in_col[cwm_pkg::COL_W-2:0]} < cfg_q.width);

	always_comb begin
		for (int r = 0; r < cwm_pkg::KSIZE; r++) begin
			hi[r] = $signed({2'b00, row_base}) + $signed(HI_W'(r))
				- $signed(HI_W'(cfg_q.padding));
			row_in[r] = !hi[r][HI_W-1] && (hi[r] < $signed(HI_W'(cfg_q.height)));
		end
	end

	always_comb begin
		if (func == cwm_pkg::FUNC_PIXEL) begin
			cmd.op = cwm_pkg::OP_PIXEL;
		end else if (kernel_row < cwm_pkg::KROW_W'(cwm_pkg::KSIZE)) begin
			cmd.op = cwm_pkg::OP_WEIGHT;
		end else begin
			cmd.op = cwm_pkg::OP_NOP;
		end
		cmd.lane  = lane;
		cmd.krow  = kernel_row;
		cmd.emit  = (func == cwm_pkg::FUNC_PIXEL) && emit;
		cmd.prior = prior_sum;
		for (int r = 0; r < cwm_pkg::KSIZE; r++) begin
			// weights pass untouched, pixels outside the image become zero
			cmd.vals[r] = ((func == cwm_pkg::FUNC_WEIGHT) || (row_in[r] && col_in))
				? vin[r] : '0;
		end
	end

endmodule

// ===== rtl/cwm_back.sv =====
// ----------------------------------------------------------------------------
// cwm_back
// window and kernel stores, pipelined multiply and adder tree
// ----------------------------------------------------------------------------
module cwm_back #(
	parameter int LANES = cwm_pkg::LANES_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cwm_pkg::cmd_t                     cmd,
	input  logic                              cmd_valid,
	output logic                              cmd_pop,
	input  logic [cwm_pkg::OUT_CNT_W-1:0]     out_count,
	output logic                              res_valid,
	output logic [cwm_pkg::SUM_W-1:0]         res_sum
);

	localparam int K      = cwm_pkg::KSIZE;
	localparam int GROUPS = (LANES + cwm_pkg::GROUP_LANES - 1) / cwm_pkg::GROUP_LANES;
	localparam int USED_W = cwm_pkg::OUT_CNT_W + 1;

	cwm_pkg::pix_t win_q [LANES][K][K];
	cwm_pkg::pix_t wgt_q [LANES][K][K];

	logic signed [cwm_pkg::PROD_W-1:0] prod_s2  [LANES][cwm_pkg::TAPS];
	logic signed [cwm_pkg::LSUM_W-1:0] lane_c   [LANES];
	logic signed [cwm_pkg::LSUM_W-1:0] lane_s3  [LANES];
	logic signed [cwm_pkg::GSUM_W-1:0] grp_c    [GROUPS];
	logic signed [cwm_pkg::GSUM_W-1:0] grp_s4   [GROUPS];

	logic                       emit_s1, emit_s2, emit_s3, emit_s4;
	logic [cwm_pkg::SUM_W-1:0]  prior_s1, prior_s2, prior_s3, prior_s4;
	logic [USED_W-1:0]          used;
	logic                       credit_ok;

	// results queued plus sums still in the tree must leave room for one more
	assign used = USED_W'(out_count) + USED_W'(emit_s1) + USED_W'(emit_s2)
		+ USED_W'(emit_s3) + USED_W'(emit_s4);
	assign credit_ok = used < USED_W'(cwm_pkg::OUT_DEPTH);
	assign cmd_pop   = cmd_valid && (!cmd.emit || credit_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LANES; l++) begin
				for (int r = 0; r < K; r++) begin
					for (int c = 0; c < K; c++) begin
						win_q[l][r][c] <= '0;
						wgt_q[l][r][c] <= '0;
					end
				end
			end
		end else if (cmd_pop) begin
			for (int l = 0; l < LANES; l++) begin
				if (int'(cmd.lane) == l) begin
					if (cmd.op == cwm_pkg::OP_PIXEL) begin
						for (int r = 0; r < K; r++) begin
							for (int c = 0; c < K - 1; c++) begin
								win_q[l][r][c] <= win_q[l][r][c+1];
							end
							win_q[l][r][K-1] <= cmd.vals[r];
						end
					end else if (cmd.op == cwm_pkg::OP_WEIGHT) begin
						for (int c = 0; c < K; c++) begin
							wgt_q[l][cmd.krow][c] <= cmd.vals[c];
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1 <= 1'b0;
			emit_s2 <= 1'b0;
			emit_s3 <= 1'b0;
			emit_s4 <= 1'b0;
		end else begin
			emit_s1 <= cmd_pop && cmd.emit;
			emit_s2 <= emit_s1;
			emit_s3 <= emit_s2;
			emit_s4 <= emit_s3;
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			lane_c[l] = '0;
			for (int t = 0; t < cwm_pkg::TAPS; t++) begin
				lane_c[l] = lane_c[l] + cwm_pkg::LSUM_W'(prod_s2[l][t]);
			end
		end
	end

	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			grp_c[g] = '0;
			for (int j = 0; j < cwm_pkg::GROUP_LANES; j++) begin
				if (g * cwm_pkg::GROUP_LANES + j < LANES) begin
					grp_c[g] = grp_c[g]
						+ cwm_pkg::GSUM_W'(lane_s3[g * cwm_pkg::GROUP_LANES + j]);
				end
			end
		end
	end

	// stores already hold the emitting item's update during s1
	always_ff @(posedge clk) begin
		prior_s1 <= cmd.prior;
		prior_s2 <= prior_s1;
		prior_s3 <= prior_s2;
		prior_s4 <= prior_s3;
		for (int l = 0; l < LANES; l++) begin
			for (int r = 0; r < K; r++) begin
				for (int c = 0; c < K; c++) begin
					prod_s2[l][r*K+c] <= cwm_pkg::PROD_W'(win_q[l][r][c])
						* cwm_pkg::PROD_W'(wgt_q[l][r][c]);
				end
			end
			lane_s3[l] <= lane_c[l];
		end
		for (int g = 0; g < GROUPS; g++) begin
			grp_s4[g] <= grp_c[g];
		end
	end

	always_comb begin
		res_sum = prior_s4;
		for (int g = 0; g < GROUPS; g++) begin
			res_sum = res_sum + cwm_pkg::SUM_W'(grp_s4[g]);
		end
	end

	assign res_valid = emit_s4;

endmodule

// ===== rtl/conv3x3_window_mac_engine.sv =====
// ----------------------------------------------------------------------------
// conv3x3_window_mac_engine
// sliding 3x3 window convolution over a group of channel lanes
// ----------------------------------------------------------------------------
// throughput: one item per clock; the back end only holds off an emitting
//   item when queued results plus sums in the adder tree reach eight
// reset: registers return to 112 x 112, stride 1, padding 1; every window
//   and kernel tap clears to zero and both queues empty
module conv3x3_window_mac_engine #(
	parameter int LANES = cwm_pkg::LANES_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes
	input  logic                                wr_en,
	input  logic [cwm_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [cwm_pkg::DIM_W-1:0]           wr_data,
	// input beats
	input  logic                                push,
	output logic                                full,
	input  logic                                func,
	input  logic [cwm_pkg::LANE_W-1:0]          lane,
	input  logic [cwm_pkg::KROW_W-1:0]          kernel_row,
	input  logic signed [cwm_pkg::PIX_W-1:0]    first_value,
	input  logic signed [cwm_pkg::PIX_W-1:0]    second_value,
	input  logic signed [cwm_pkg::PIX_W-1:0]    third_value,
	input  logic [cwm_pkg::ROW_W-1:0]           out_row,
	input  logic signed [cwm_pkg::COL_W-1:0]    in_col,
	input  logic                                emit,
	input  logic signed [cwm_pkg::SUM_W-1:0]    prior_sum,
	// result beats
	output logic                                empty,
	input  logic                                pop,
	output logic signed [cwm_pkg::SUM_W-1:0]    output_sum
);

	localparam int CMD_W = $bits(cwm_pkg::cmd_t);

	cwm_pkg::cmd_t                    front_cmd;
	cwm_pkg::cmd_t                    mid_cmd;
	logic [CMD_W-1:0]                 mid_dout;
	logic                             mid_empty;
	logic                             cmd_pop;
	logic [cwm_pkg::OUT_CNT_W-1:0]    out_count;
	logic                             res_valid;
	logic [cwm_pkg::SUM_W-1:0]        res_sum;
	logic [cwm_pkg::SUM_W-1:0]        out_dout;

	// front end: geometry registers, border zeroing, op decode
	cwm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.func         (func),
		.lane         (lane),
		.kernel_row   (kernel_row),
		.first_value  (first_value),
		.second_value (second_value),
		.third_value  (third_value),
		.out_row      (out_row),
		.in_col       (in_col),
		.emit         (emit),
		.prior_sum    (prior_sum),
		.cmd          (front_cmd)
	);

	// decoupling queue between classification and the stores
	cwm_fifo #(
		.W     (CMD_W),
		.DEPTH (cwm_pkg::MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (cmd_pop),
		.din    (front_cmd),
		.dout   (mid_dout),
		.count  (),
		.full   (full),
		.empty  (mid_empty)
	);

	assign mid_cmd = cwm_pkg::cmd_t'(mid_dout);

	// back end: window shift, kernel load, multiply and reduce
	cwm_back #(
		.LANES (LANES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (mid_cmd),
		.cmd_valid (!mid_empty),
		.cmd_pop   (cmd_pop),
		.out_count (out_count),
		.res_valid (res_valid),
		.res_sum   (res_sum)
	);

	// result queue, sized so the back end never overruns it
	cwm_fifo #(
		.W     (cwm_pkg::SUM_W),
		.DEPTH (cwm_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.pop    (pop),
		.din    (res_sum),
		.dout   (out_dout),
		.count  (out_count),
		.full   (),
		.empty  (empty)
	);

	assign output_sum = $signed(out_dout);

endmodule

// ===== rtl/cwm_checker.sv =====
// ----------------------------------------------------------------------------
// cwm_checker
// port-level checks of the result side, bound to the engine
// ----------------------------------------------------------------------------
`include "conv3x3_window_mac_engine_assert.svh"

module cwm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               empty,
	input logic                               pop,
	input logic signed [cwm_pkg::SUM_W-1:0]   output_sum
);

	// reset leaves no result waiting
	`CWM_ASSERT_ALWAYS(a_rst_empty, !arst_n, empty)

	// a sum must cross the mid queue, the multiply pipeline and the result queue
	`CWM_ASSERT_ALWAYS(a_rst_latency, !$past(arst_n, 4), empty)

	// a waiting result holds until taken
	`CWM_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(output_sum))

endmodule

bind conv3x3_window_mac_engine cwm_checker u_cwm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.output_sum (output_sum)
);

// ===== sim/window_sum_checker.sv =====
// ----------------------------------------------------------------------------
// window_sum_checker
// watches the engine's ports, keeps its own copy of every lane's window and
// kernel, and checks each output_sum beat against the oldest predicted sum
// ----------------------------------------------------------------------------
module window_sum_checker #(
	parameter int LANES = cwm_pkg::LANES_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [cwm_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [cwm_pkg::DIM_W-1:0]           wr_data,
	input  logic                                push,
	input  logic                                full,
	input  logic                                func,
	input  logic [cwm_pkg::LANE_W-1:0]          lane,
	input  logic [cwm_pkg::KROW_W-1:0]          kernel_row,
	input  logic signed [cwm_pkg::PIX_W-1:0]    first_value,
	input  logic signed [cwm_pkg::PIX_W-1:0]    second_value,
	input  logic signed [cwm_pkg::PIX_W-1:0]    third_value,
	input  logic [cwm_pkg::ROW_W-1:0]           out_row,
	input  logic signed [cwm_pkg::COL_W-1:0]    in_col,
	input  logic                                emit,
	input  logic signed [cwm_pkg::SUM_W-1:0]    prior_sum,
	input  logic                                empty,
	input  logic                                pop,
	input  logic signed [cwm_pkg::SUM_W-1:0]    output_sum,
	output int                                  mismatches,
	output int                                  sums_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import cwm_pkg::*;

	cfg_t                    geom;
	pix_t                    window_taps [LANES*TAPS];
	pix_t                    kernel_taps [LANES*TAPS];
	logic signed [SUM_W-1:0] sums_due [$];
	logic signed [SUM_W-1:0] want;

	// dot product of every lane's window with its kernel, 32-bit wrap
	function automatic logic signed [SUM_W-1:0] window_dot();
		int acc = 0;
		for (int i = 0; i < LANES*TAPS; i++)
			acc += int'(window_taps[i]) * int'(kernel_taps[i]);
		return SUM_W'(acc);
	endfunction

	task automatic take_beat();
		pix_t vals [KSIZE];
		int   base;
		int   rb;
		int   row;
		bit   col_in;
		bit   row_in;
		vals[0] = first_value;
		vals[1] = second_value;
		vals[2] = third_value;
		if (func == FUNC_WEIGHT) begin
			// kernel row three writes nothing, emit is ignored
			if (lane < LANES && kernel_row < KSIZE) begin
				base = int'(lane) * TAPS + int'(kernel_row) * KSIZE;
				for (int c = 0; c < KSIZE; c++)
					kernel_taps[base + c] = vals[c];
			end
		end else begin
			if (lane < LANES) begin
				base = int'(lane) * TAPS;
				col_in = in_col >= 0 && int'(in_col) < int'(geom.width);
				for (int r = 0; r < KSIZE; r++) begin
					row = int'(out_row) * int'(geom.stride) + r - int'(geom.padding);
					row_in = row >= 0 && row < int'(geom.height);
					rb = base + r * KSIZE;
					for (int c = 0; c + 1 < KSIZE; c++)
						window_taps[rb + c] = window_taps[rb + c + 1];
					window_taps[rb + KSIZE - 1] = (row_in && col_in) ? vals[r] : pix_t'(0);
				end
			end
			if (emit)
				sums_due.push_back(prior_sum + window_dot());
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom = '{HEIGHT_RST, WIDTH_RST, STRIDE_RST, PADDING_RST};
			foreach (window_taps[i]) window_taps[i] = '0;
			foreach (kernel_taps[i]) kernel_taps[i] = '0;
			sums_due.delete();
			mismatches = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_HEIGHT:  geom.height  = wr_data;
					REG_WIDTH:   geom.width   = wr_data;
					REG_STRIDE:  geom.stride  = wr_data[STRIDE_W-1:0];
					REG_PADDING: geom.padding = wr_data[PAD_W-1:0];
					default: ;
				endcase
			end
			// results leave before this edge's input can add one
			if (pop && !empty) begin
				if (sums_due.size() == 0) begin
					mismatches++;
					$display("%0t ns: unexpected output_sum beat, expected none, got %0d",
						$time, output_sum);
				end else begin
					want = sums_due.pop_front();
					if (output_sum !== want) begin
						mismatches++;
						$display("%0t ns: output_sum mismatch, expected %0d, got %0d",
							$time, want, output_sum);
					end
				end
			end
			if (push && !full)
				take_beat();
		end
		sums_pending = sums_due.size();
	end

endmodule

// ===== sim/conv3x3_window_mac_engine_test.sv =====
// ----------------------------------------------------------------------------
// conv3x3_window_mac_engine_test
// drives weight and pixel beats into the 3x3 window engine over a series of
// image geometries and handshake pressures; a side checker predicts every
// window sum and this module gives the verdict
// ----------------------------------------------------------------------------
module conv3x3_window_mac_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cwm_pkg::*;

	localparam int LANES       = LANES_DEFAULT;
	localparam int PHASES      = 8;
	localparam int PHASE_BEATS = 165;
	localparam int SETTLE      = 12;        // margin for the mid queue and the multiply pipeline to empty
	localparam int CYCLE_LIMIT = 400_000;

	// one input beat as the engine sees it
	typedef struct packed {
		logic                    func;
		logic [LANE_W-1:0]       lane;
		logic [KROW_W-1:0]       krow;
		pix_t                    first;
		pix_t                    second;
		pix_t                    third;
		logic [ROW_W-1:0]        out_row;
		logic signed [COL_W-1:0] in_col;
		logic                    emit;
		logic signed [SUM_W-1:0] prior;
	} engine_beat_t;

	logic                    clk;
	logic                    arst_n;
	logic                    wr_en;
	logic [CFG_IDX_W-1:0]    wr_index;
	logic [DIM_W-1:0]        wr_data;
	logic                    push;
	logic                    full;
	logic                    func;
	logic [LANE_W-1:0]       lane;
	logic [KROW_W-1:0]       kernel_row;
	logic signed [PIX_W-1:0] first_value;
	logic signed [PIX_W-1:0] second_value;
	logic signed [PIX_W-1:0] third_value;
	logic [ROW_W-1:0]        out_row;
	logic signed [COL_W-1:0] in_col;
	logic                    emit;
	logic signed [SUM_W-1:0] prior_sum;
	logic                    empty;
	logic                    pop;
	logic signed [SUM_W-1:0] output_sum;

	int mismatches;
	int sums_pending;
	int cycles = 0;

	// idle and stall odds in percent, changed per phase
	int send_idle_pct  = 0;
	int pop_stall_pct  = 0;

	conv3x3_window_mac_engine #(.LANES(LANES)) DUT (.*);

	window_sum_checker #(.LANES(LANES)) u_checker (.*);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run guard: anything stuck ends here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL conv3x3_window_mac_engine");
			$finish;
		end
	end

	// result side: pop held low at random per cycle in the stalling phases
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop <= ($urandom_range(99) >= pop_stall_pct);
		end
	end

	// pixel value with the extremes well represented
	function automatic int pick_value();
		case ($urandom_range(9))
			0:       return -128;
			1:       return 127;
			2:       return 0;
			3:       return -1;
			default: return int'($urandom_range(255)) - 128;
		endcase
	endfunction

	// weight row load; the pixel-only fields carry noise
	function automatic engine_beat_t weight_beat(int ln, int kr, int a, int b, int c, bit fire);
		engine_beat_t t;
		t.func    = FUNC_WEIGHT;
		t.lane    = LANE_W'(ln);
		t.krow    = KROW_W'(kr);
		t.first   = PIX_W'(a);
		t.second  = PIX_W'(b);
		t.third   = PIX_W'(c);
		t.out_row = ROW_W'($urandom);
		t.in_col  = COL_W'($urandom);
		t.emit    = fire;
		t.prior   = SUM_W'($urandom);
		return t;
	endfunction

	// pixel column push; kernel_row is don't-care so it gets noise
	function automatic engine_beat_t pixel_beat(int ln, int a, int b, int c, int row, int col,
			bit fire, logic [SUM_W-1:0] prior);
		engine_beat_t t;
		t.func    = FUNC_PIXEL;
		t.lane    = LANE_W'(ln);
		t.krow    = KROW_W'($urandom);
		t.first   = PIX_W'(a);
		t.second  = PIX_W'(b);
		t.third   = PIX_W'(c);
		t.out_row = ROW_W'(row);
		t.in_col  = COL_W'(col);
		t.emit    = fire;
		t.prior   = prior;
		return t;
	endfunction

	// mostly near the image origin so both padding edges get hit, with
	// the odd full-range row and column for the upper bits
	function automatic engine_beat_t random_beat();
		int row;
		int col;
		row = ($urandom_range(4) == 0) ? int'($urandom_range(4095)) : int'($urandom_range(9));
		col = ($urandom_range(4) == 0) ? int'($urandom_range(8191)) - 4096
			: int'($urandom_range(12)) - 3;
		if ($urandom_range(3) == 0)
			return weight_beat($urandom_range(15),
				($urandom_range(7) == 0) ? 3 : int'($urandom_range(2)),
				pick_value(), pick_value(), pick_value(), 1'($urandom_range(1)));
		return pixel_beat($urandom_range(15), pick_value(), pick_value(), pick_value(),
			row, col, $urandom_range(9) < 3, $urandom);
	endfunction

	// one beat through push/full; called and returning at a falling edge,
	// push stays high on return so back-to-back beats need no toggle
	task automatic feed_beat(input engine_beat_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push         <= 1'b1;
		func         <= t.func;
		lane         <= t.lane;
		kernel_row   <= t.krow;
		first_value  <= t.first;
		second_value <= t.second;
		third_value  <= t.third;
		out_row      <= t.out_row;
		in_col       <= t.in_col;
		emit         <= t.emit;
		prior_sum    <= t.prior;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	// a proper window build: three columns across the first few lanes,
	// summed once the last lane's third column is in
	task automatic sweep_window(output int beats);
		int lanes_used;
		int row;
		int first_col;
		lanes_used = $urandom_range(1, 4);
		row        = $urandom_range(6);
		first_col  = int'($urandom_range(8)) - 2;
		for (int col = 0; col < KSIZE; col++)
			for (int ln = 0; ln < lanes_used; ln++)
				feed_beat(pixel_beat(ln, pick_value(), pick_value(), pick_value(), row,
					first_col + col, col == KSIZE - 1 && ln == lanes_used - 1, $urandom));
		beats = KSIZE * lanes_used;
	endtask

	// all four registers, one write per cycle
	task automatic write_geometry(input cfg_t g);
		wr_en    <= 1'b1;
		wr_index <= REG_HEIGHT;
		wr_data  <= g.height;
		@(negedge clk);
		wr_index <= REG_WIDTH;
		wr_data  <= g.width;
		@(negedge clk);
		wr_index <= REG_STRIDE;
		wr_data  <= DIM_W'(g.stride);
		@(negedge clk);
		wr_index <= REG_PADDING;
		wr_data  <= DIM_W'(g.padding);
		@(negedge clk);
		wr_en    <= 1'b0;
	endtask

	// stop feeding, wait for every predicted sum, then let non-emitting
	// beats still in the pipe finish before the geometry moves
	task automatic drain();
		push <= 1'b0;
		while (sums_pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		cfg_t geometry_plan [PHASES];
		int   idle_plan [4];
		int   stall_plan [4];
		int   sent;
		int   n;

		// every input known from time zero
		arst_n       = 1'b0;
		wr_en        = 1'b0;
		wr_index     = REG_HEIGHT;
		wr_data      = '0;
		push         = 1'b0;
		func         = FUNC_WEIGHT;
		lane         = '0;
		kernel_row   = '0;
		first_value  = '0;
		second_value = '0;
		third_value  = '0;
		out_row      = '0;
		in_col       = '0;
		emit         = 1'b0;
		prior_sum    = '0;

		// no idling, sender idle, receiver stalling, then both lightly
		idle_plan  = '{0, 77, 0, 30};
		stall_plan = '{0, 0, 77, 30};

		// small images, the bottom and top of the legal ranges, all zeros
		// (every pixel zeroed, stride zero), all ones in every register bit
		geometry_plan[0] = '{13'd5, 13'd6, 3'd2, 2'd2};
		geometry_plan[1] = '{13'd1, 13'd1, 3'd1, 2'd0};
		geometry_plan[2] = '{13'd4096, 13'd4096, 3'd4, 2'd3};
		geometry_plan[3] = '{13'd0, 13'd0, 3'd0, 2'd0};
		geometry_plan[4] = '{13'd8191, 13'd8191, 3'd7, 2'd3};
		geometry_plan[5] = '{13'd3, 13'd4, 3'd1, 2'd1};
		for (int p = 6; p < PHASES; p++)
			geometry_plan[p] = '{DIM_W'($urandom_range(1, 8)), DIM_W'($urandom_range(1, 8)),
				STRIDE_W'($urandom_range(7)), PAD_W'($urandom_range(3))};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part under the reset geometry: 112 x 112, stride 1, pad 1
		feed_beat(weight_beat(0, 0, -128, -128, -128, 1'b0));
		feed_beat(weight_beat(0, 1, 127, 127, 127, 1'b0));
		feed_beat(weight_beat(0, 2, -128, 127, -1, 1'b0));
		feed_beat(weight_beat(15, 0, 127, -128, 1, 1'b0));
		feed_beat(weight_beat(15, 1, -1, -1, -1, 1'b0));
		// emit on a weight load gives nothing back
		feed_beat(weight_beat(15, 2, 127, 127, 127, 1'b1));
		// kernel row three must leave lane 0's kernel alone
		feed_beat(weight_beat(0, 3, 5, 5, 5, 1'b0));
		// top window row above the image
		feed_beat(pixel_beat(0, -128, -128, -128, 0, 0, 1'b1, 0));
		feed_beat(pixel_beat(0, -128, -128, -128, 1, 1, 1'b0, 0));
		// prior at the largest positive sum
		feed_beat(pixel_beat(0, 127, 127, 127, 1, 2, 1'b1, 32'h7fff_ffff));
		// column left of the image, then right edge and just past it
		feed_beat(pixel_beat(15, 127, 127, 127, 1, -1, 1'b1, 32'h8000_0000));
		feed_beat(pixel_beat(15, -128, -128, -128, 1, 111, 1'b0, 0));
		feed_beat(pixel_beat(15, -128, -128, -128, 1, 112, 1'b1, -1));
		// bottom window row below the image
		feed_beat(pixel_beat(15, -128, -128, -128, 111, 110, 1'b1, 0));
		// field extremes
		feed_beat(pixel_beat(7, 127, 127, 127, 4095, 4095, 1'b1, 32'h5555_5555));
		feed_beat(pixel_beat(7, -128, 127, -128, 0, -4096, 1'b1, 32'haaaa_aaaa));
		feed_beat(pixel_beat(0, -128, -128, -128, 2, 3, 1'b1, 32'h7fff_ffff));
		feed_beat(pixel_beat(0, -128, -128, -128, 2, 4, 1'b1, 32'h8000_0000));
		feed_beat(weight_beat(3, 2, 0, 0, 0, 1'b0));
		feed_beat(pixel_beat(3, 1, 2, 3, 1, 5, 1'b1, 0));
		drain();

		// random phases, each under a new geometry and handshake pressure
		for (int p = 0; p < PHASES; p++) begin
			write_geometry(geometry_plan[p]);
			send_idle_pct = idle_plan[p % 4];
			pop_stall_pct = stall_plan[p % 4];
			sent = 0;
			while (sent < PHASE_BEATS) begin
				if ($urandom_range(3) == 0) begin
					sweep_window(n);
					sent += n;
				end else begin
					feed_beat(random_beat());
					sent++;
				end
			end
			drain();
		end

		if (mismatches == 0)
			$display("PASS conv3x3_window_mac_engine");
		else
			$display("FAIL conv3x3_window_mac_engine");
		$finish;
	end

endmodule

// ===== conv3x3_window_mac_engine.f =====
+incdir+rtl
rtl/cwm_pkg.sv
rtl/cwm_fifo.sv
rtl/cwm_front.sv
rtl/cwm_back.sv
rtl/conv3x3_window_mac_engine.sv
rtl/cwm_checker.sv
sim/window_sum_checker.sv
sim/conv3x3_window_mac_engine_test.sv
